// ===== rtl/srctok_pkg.sv =====
`timescale 1ns / 1ps
package srctok_pkg;

   localparam int DEFAULT_OFFSET_BITS = 16;
   localparam int KIND_BITS           = 5;
   localparam int RSP_DEPTH           = 4;
   localparam int RSP_PTR_BITS        = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS        = $clog2(RSP_DEPTH + 3);

   typedef logic [KIND_BITS-1:0] kind_type;

   localparam kind_type KIND_END     = 5'd0;
   localparam kind_type KIND_UNKNOWN = 5'd1;
   localparam kind_type KIND_ASSIGN  = 5'd2;
   localparam kind_type KIND_EQUAL   = 5'd3;
   localparam kind_type KIND_NOTEQ   = 5'd4;
   localparam kind_type KIND_STAR    = 5'd5;
   localparam kind_type KIND_SLASH   = 5'd6;
   localparam kind_type KIND_PERCENT = 5'd7;
   localparam kind_type KIND_GT      = 5'd8;
   localparam kind_type KIND_LT      = 5'd9;
   localparam kind_type KIND_MINUS   = 5'd10;
   localparam kind_type KIND_PLUS    = 5'd11;
   localparam kind_type KIND_COMMA   = 5'd12;
   localparam kind_type KIND_SEMI    = 5'd13;
   localparam kind_type KIND_LPAREN  = 5'd14;
   localparam kind_type KIND_RPAREN  = 5'd15;
   localparam kind_type KIND_LBRACE  = 5'd16;
   localparam kind_type KIND_RBRACE  = 5'd17;
   localparam kind_type KIND_LBRACK  = 5'd18;
   localparam kind_type KIND_RBRACK  = 5'd19;
   localparam kind_type KIND_INTEGER = 5'd20;
   localparam kind_type KIND_IDENT   = 5'd21;
   localparam kind_type KIND_FN      = 5'd22;
   localparam kind_type KIND_IF      = 5'd23;
   localparam kind_type KIND_LET     = 5'd24;
   localparam kind_type KIND_ELSE    = 5'd25;
   localparam kind_type KIND_PRINT   = 5'd26;
   localparam kind_type KIND_WHILE   = 5'd27;
   localparam kind_type KIND_RETURN  = 5'd28;

   localparam int KW_CHARS = 6;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_EQ,
      MODE_BANG
   } scan_mode_type;

   typedef logic [KW_CHARS-1:0][7:0] kw_chars_type;

   function automatic kind_type op_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "%":     k = KIND_PERCENT;
         ">":     k = KIND_GT;
         "<":     k = KIND_LT;
         "-":     k = KIND_MINUS;
         "+":     k = KIND_PLUS;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // len is valid only when short is set (identifier of at most six bytes)
   function automatic kind_type kw_kind(input logic short, input logic [2:0] len,
                                        input kw_chars_type ch);
      kind_type k;
      k = KIND_IDENT;
      if (short) begin
         case (len)
            3'd2: begin
               if (ch[0] == "f" && ch[1] == "n") k = KIND_FN;
               else if (ch[0] == "i" && ch[1] == "f") k = KIND_IF;
            end
            3'd3: begin
               if (ch[0] == "l" && ch[1] == "e" && ch[2] == "t") k = KIND_LET;
            end
            3'd4: begin
               if (ch[0] == "e" && ch[1] == "l" && ch[2] == "s" && ch[3] == "e")
                  k = KIND_ELSE;
            end
            3'd5: begin
               if (ch[0] == "p" && ch[1] == "r" && ch[2] == "i" && ch[3] == "n"
                   && ch[4] == "t")
                  k = KIND_PRINT;
               else if (ch[0] == "w" && ch[1] == "h" && ch[2] == "i" && ch[3] == "l"
                        && ch[4] == "e")
                  k = KIND_WHILE;
            end
            3'd6: begin
               if (ch[0] == "r" && ch[1] == "e" && ch[2] == "t" && ch[3] == "u"
                   && ch[4] == "r" && ch[5] == "n")
                  k = KIND_RETURN;
            end
            default: k = KIND_IDENT;
         endcase
      end
      return k;
   endfunction

endpackage

// ===== rtl/srctok_req_if.sv =====
`timescale 1ns / 1ps
interface srctok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

// ===== rtl/srctok_rsp_if.sv =====
`timescale 1ns / 1ps
interface srctok_rsp_if #(
   parameter int OFFSET_BITS = srctok_pkg::DEFAULT_OFFSET_BITS
);
   logic                         valid;
   logic                         ready;
   logic [srctok_pkg::KIND_BITS-1:0] token_kind;
   logic [OFFSET_BITS-1:0]       start_offset;
   logic [OFFSET_BITS-1:0]       token_length;
   logic [OFFSET_BITS-1:0]       line_number;
   logic                         last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output line_number, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input start_offset,
                   input token_length, input line_number, input last_of_run,
                   output ready);
endinterface

// ===== rtl/source_tokenizer_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                               Per request
// req       in   char_byte[7:0]                                        one source byte
// rsp       out  token_kind, start_offset, token_length, line_number,  one token
//                last_of_run
//
// A byte is registered, tokenized in the next cycle and its 0..2 tokens are
// written into a 4-entry output queue; rsp.valid follows the registered queue
// count. One byte per cycle while req.ready stays high. req.ready is low while
// queued tokens plus those of the byte in flight exceed two, so a byte that
// closes one token and emits another stalls the next request while a token is
// still queued. Reset is synchronous: line 1, offset 0, between tokens; a zero
// byte ends the text and restores that same state.
module source_tokenizer_top #(
   parameter int OFFSET_BITS = srctok_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic         clock,
   input  logic         reset,
   srctok_req_if.sink   req,
   srctok_rsp_if.source rsp
);

   localparam int PB = srctok_pkg::RSP_PTR_BITS;
   localparam int CB = srctok_pkg::RSP_CNT_BITS;

   typedef struct packed {
      srctok_pkg::kind_type   kind;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] len;
      logic [OFFSET_BITS-1:0] line;
      logic                   last;
   } token_type;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] x);
      return (x == '1) ? x : x + 1'b1;
   endfunction

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   srctok_pkg::scan_mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]    start_ff, start_in;
   logic [OFFSET_BITS-1:0]    offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]    line_ff, line_in;
   logic [OFFSET_BITS-1:0]    len_ff, len_in;
   logic [7:0]                kw_ff [srctok_pkg::KW_CHARS];
   logic                      kw_we;
   logic [2:0]                kw_idx;
   srctok_pkg::kw_chars_type  kw_chars;

   token_type                 res_a, res_b;
   logic                      push_a, push_b;
   logic [1:0]                npush;

   token_type                 q_ff [srctok_pkg::RSP_DEPTH];
   logic [PB-1:0]             wr_ff, rd_ff;
   logic [CB-1:0]             count_ff;
   logic                      pop;
   logic                      accept;
   logic                      fresh;
   logic [7:0]                c;

   assign accept    = req.valid && req.ready;
   assign req.ready = (count_ff + CB'(npush)) <= CB'(srctok_pkg::RSP_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      if (accept) begin
         in_byte_ff <= req.char_byte;
      end
   end

   always_comb begin
      for (int i = 0; i < srctok_pkg::KW_CHARS; i++) begin
         kw_chars[i] = kw_ff[i];
      end
   end

   assign c = in_byte_ff;

   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      len_in    = len_ff;
      kw_we     = 1'b0;
      kw_idx    = len_ff[2:0];
      push_a    = 1'b0;
      push_b    = 1'b0;
      fresh     = 1'b1;
      res_a     = '{kind: srctok_pkg::KIND_IDENT, start: start_ff, len: len_ff,
                    line: line_ff, last: 1'b0};
      res_b     = '{kind: srctok_pkg::KIND_END, start: offset_ff, len: '0,
                    line: line_ff, last: 1'b1};

      if (in_valid_ff) begin
         // close out or extend the pending token
         case (mode_ff)
            srctok_pkg::MODE_IDENT: begin
               if (c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f}) begin
                  kw_we  = len_ff < OFFSET_BITS'(srctok_pkg::KW_CHARS);
                  len_in = sat_inc(len_ff);
                  fresh  = 1'b0;
               end else begin
                  push_a     = 1'b1;
                  res_a.kind = srctok_pkg::kw_kind(
                     len_ff <= OFFSET_BITS'(srctok_pkg::KW_CHARS), len_ff[2:0], kw_chars);
               end
            end
            srctok_pkg::MODE_INT: begin
               if (c inside {[8'h30:8'h39]}) begin
                  len_in = sat_inc(len_ff);
                  fresh  = 1'b0;
               end else begin
                  push_a     = 1'b1;
                  res_a.kind = srctok_pkg::KIND_INTEGER;
               end
            end
            srctok_pkg::MODE_EQ: begin
               push_a = 1'b1;
               if (c == "=") begin
                  res_a.kind = srctok_pkg::KIND_EQUAL;
                  res_a.len  = OFFSET_BITS'(2);
                  fresh      = 1'b0;
               end else begin
                  res_a.kind = srctok_pkg::KIND_ASSIGN;
                  res_a.len  = OFFSET_BITS'(1);
               end
            end
            srctok_pkg::MODE_BANG: begin
               push_a = 1'b1;
               if (c == "=") begin
                  res_a.kind = srctok_pkg::KIND_NOTEQ;
                  res_a.len  = OFFSET_BITS'(2);
                  fresh      = 1'b0;
               end else begin
                  res_a.kind = srctok_pkg::KIND_UNKNOWN;
                  res_a.len  = OFFSET_BITS'(1);
               end
            end
            default: begin
            end
         endcase

         if (push_a || !(mode_ff == srctok_pkg::MODE_IDENT || mode_ff == srctok_pkg::MODE_INT))
            mode_in = srctok_pkg::MODE_IDLE;

         offset_in = sat_inc(offset_ff);

         if (fresh) begin
            if (c == 8'h00) begin
               push_b    = 1'b1;
               mode_in   = srctok_pkg::MODE_IDLE;
               start_in  = '0;
               offset_in = '0;
               line_in   = OFFSET_BITS'(1);
               len_in    = '0;
            end else if (c inside {8'h20, [8'h09:8'h0d]}) begin
               if (c == 8'h0a) line_in = sat_inc(line_ff);
            end else if (c inside {[8'h61:8'h7a], [8'h41:8'h5a]}) begin
               mode_in  = srctok_pkg::MODE_IDENT;
               start_in = offset_ff;
               len_in   = OFFSET_BITS'(1);
               kw_we    = 1'b1;
               kw_idx   = 3'd0;
            end else if (c inside {[8'h30:8'h39]}) begin
               mode_in  = srctok_pkg::MODE_INT;
               start_in = offset_ff;
               len_in   = OFFSET_BITS'(1);
            end else if (c == "=") begin
               mode_in  = srctok_pkg::MODE_EQ;
               start_in = offset_ff;
            end else if (c == "!") begin
               mode_in  = srctok_pkg::MODE_BANG;
               start_in = offset_ff;
            end else begin
               push_b      = 1'b1;
               res_b.kind  = srctok_pkg::op_kind(c);
               res_b.len   = OFFSET_BITS'(1);
            end
         end
      end
      res_a.last = !push_b;
      npush      = {1'b0, push_a} + {1'b0, push_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= srctok_pkg::MODE_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         line_ff   <= OFFSET_BITS'(1);
         len_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         len_ff    <= len_in;
      end
      if (kw_we) begin
         kw_ff[kw_idx] <= c;
      end
   end

   // output queue
   assign pop = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + PB'(npush);
         rd_ff    <= rd_ff + PB'(pop);
         count_ff <= count_ff + CB'(npush) - CB'(pop);
      end
      if (push_a) begin
         q_ff[wr_ff] <= res_a;
      end
      if (push_b) begin
         q_ff[wr_ff + PB'(push_a)] <= res_b;
      end
   end

   assign rsp.valid        = count_ff != '0;
   assign rsp.token_kind   = q_ff[rd_ff].kind;
   assign rsp.start_offset = q_ff[rd_ff].start;
   assign rsp.token_length = q_ff[rd_ff].len;
   assign rsp.line_number  = q_ff[rd_ff].line;
   assign rsp.last_of_run  = q_ff[rd_ff].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(srctok_pkg::RSP_DEPTH))
      else $error("output queue overflow");

   a_room_for_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> count_ff <= CB'(srctok_pkg::RSP_DEPTH - 2))
      else $error("byte in flight without room for two tokens");

   a_end_restores: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_byte_ff == 8'h00) |=>
         (offset_ff == '0 && line_ff == OFFSET_BITS'(1)
          && mode_ff == srctok_pkg::MODE_IDLE))
      else $error("end of text did not restore initial state");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.token_kind == srctok_pkg::KIND_END) |-> rsp.last_of_run)
      else $error("end token not marked last");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count reached zero");

endmodule
